/* rtl/core/bpw_pkg.sv */
package bpw_pkg;

    // Storage size and derived widths
    localparam int MAX_ATOMS = 16;
    localparam int ADDR_W    = $clog2(MAX_ATOMS);
    localparam int CNT_W     = $clog2(MAX_ATOMS + 1);
    localparam int TOT_W     = 32 + ADDR_W;
    localparam int DIV_W     = TOT_W;

    // Fixed-point constants
    localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
    localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
    localparam logic [63:0] SQRT_TOP  = 64'h4000_0000_0000_0000;
    localparam logic [5:0]  DIV_U_STEPS = 6'd31;
    localparam logic [5:0]  DIV_W_STEPS = 6'd32;

    // Item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_COINC  = 2'd1,
        ST_ZERO   = 2'd2,
        ST_BADIDX = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_STORE,
        OP_LOAD_PT,
        OP_DIFF_PT,
        OP_DIFF_CI,
        OP_SQUARE,
        OP_SUM,
        OP_SQRT_GO,
        OP_LAM_WR,
        OP_ROW_LATCH,
        OP_UPREP,
        OP_A_SAT,
        OP_DIV_U_GO,
        OP_TAKE_Q,
        OP_A2,
        OP_A3,
        OP_PP,
        OP_WMUL,
        OP_ROW_END,
        OP_DIV_W_GO,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [ADDR_W-1:0] addr;
        logic              tgt;
        status_t           st;
    } dp_cmd_t;

    typedef struct packed {
        logic sqrt_busy;
        logic div_busy;
        logic root_zero;
        logic u_sat;
        logic total_zero;
    } dp_stat_t;

endpackage

/* rtl/core/becke_partition_weight.sv */
// Becke fuzzy-cell partition weight, three smoothing steps.
// Input channel (in_valid/in_ready): cmd 0 stores the atom centre
// coord_x/y/z into slot atom_index (no result); cmd 1 evaluates the weight
// of target atom atom_index at grid point coord_x/y/z (one result).
// Output channel (out_valid/out_ready): cell_weight (unsigned Q1.31) and
// status (0 ok, 1 coincident atoms, 2 zero total, 3 bad index).
// cfg_we/cfg_wdata set the atom count n; write only while idle.
// In an evaluation of n atoms, every atom pair runs its distance through
// the shared 32-step square-root unit and, unless u saturates, its ratio
// through the shared 31-step divider, one step per cycle; the final
// normalization is a 32-step pass of the same divider.
// One transaction is processed at a time; the next is accepted as soon as
// the result sits in the output register, even if the receiver stalls.
// A finished result waits in the controller's final state only while the
// previous result is still not taken.
// Reset clears control state and sets n to 1; atom slots hold no defined
// value until loaded.
module becke_partition_weight (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [3:0]         atom_index,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        cell_weight,
    output logic [1:0]         status,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_wdata
);

    bpw_pkg::dp_cmd_t  dcmd;
    bpw_pkg::dp_stat_t dstat;

    bpw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .atom_index (atom_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .dcmd       (dcmd),
        .dstat      (dstat)
    );

    bpw_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .dcmd        (dcmd),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .dstat       (dstat),
        .cell_weight (cell_weight),
        .status      (status)
    );

endmodule

/* rtl/core/bpw_ram.sv */
module bpw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/bpw_dp.sv */
module bpw_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bpw_pkg::dp_cmd_t      dcmd,
    input  logic signed [31:0]    coord_x,
    input  logic signed [31:0]    coord_y,
    input  logic signed [31:0]    coord_z,
    output bpw_pkg::dp_stat_t     dstat,
    output logic [31:0]           cell_weight,
    output logic [1:0]            status
);

    localparam int DW = bpw_pkg::DIV_W;

    // half of |a - b|, floor
    function automatic logic [31:0] halfmag(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
        logic signed [32:0] d;
        logic [32:0]        m;
        d = $signed({a[31], a}) - $signed({b[31], b});
        m = d[32] ? 33'(-d) : 33'(d);
        return m[32:1];
    endfunction

    logic signed [31:0] pt_x_reg, pt_y_reg, pt_z_reg;
    logic signed [31:0] ci_x_reg, ci_y_reg, ci_z_reg;
    logic [31:0]        li_reg, lj_reg;
    logic [31:0]        dx_reg, dy_reg, dz_reg;
    logic [63:0]        sqx_reg, sqy_reg, sqz_reg, sum_reg;
    logic [63:0]        sv_reg, sr_reg, sbit_reg;
    logic               sq_busy_reg;
    logic [DW:0]        dr_reg;
    logic [DW-1:0]      dd_reg;
    logic [31:0]        dq_reg;
    logic [5:0]         dcnt_reg;
    logic               div_busy_reg;
    logic [31:0]        num_reg;
    logic               neg_reg;
    logic [30:0]        a_reg, a2_reg, a3_reg;
    logic [31:0]        w_reg, wt_reg;
    logic [bpw_pkg::TOT_W-1:0] total_reg;
    logic [31:0]        weight_reg;
    logic [1:0]         status_reg;

    // atom centre and distance stores
    logic [95:0]        ctr_rdata;
    logic signed [31:0] rd_x, rd_y, rd_z;
    logic [31:0]        lam_rdata;
    logic               ctr_we, lam_we;

    assign ctr_we = (dcmd.op == bpw_pkg::OP_STORE);
    assign lam_we = (dcmd.op == bpw_pkg::OP_LAM_WR);

    bpw_ram #(.WIDTH(96), .DEPTH(bpw_pkg::MAX_ATOMS)) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (dcmd.addr),
        .wdata ({coord_x, coord_y, coord_z}),
        .raddr (dcmd.addr),
        .rdata (ctr_rdata)
    );

    bpw_ram #(.WIDTH(32), .DEPTH(bpw_pkg::MAX_ATOMS)) u_lam_ram (
        .clk   (clk),
        .we    (lam_we),
        .waddr (dcmd.addr),
        .wdata (sr_reg[31:0]),
        .raddr (dcmd.addr),
        .rdata (lam_rdata)
    );

    assign rd_x = ctr_rdata[95:64];
    assign rd_y = ctr_rdata[63:32];
    assign rd_z = ctr_rdata[31:0];

    // square root step, two bits of input per cycle
    logic [63:0] sq_t;
    logic        sq_ge;
    assign sq_t  = sr_reg + sbit_reg;
    assign sq_ge = (sv_reg >= sq_t);

    // restoring divider step
    logic          dv_ge;
    logic [DW:0]   dv_rs;
    assign dv_ge = (dr_reg >= {1'b0, dd_reg});
    assign dv_rs = dv_ge ? (dr_reg - {1'b0, dd_reg}) : dr_reg;

    // smoothing polynomial and weight product
    logic [61:0] a2_prod, a3_prod;
    logic [31:0] pp_sum, s_val;
    logic [63:0] w_prod;
    assign a2_prod = 62'(a_reg) * 62'(a_reg);
    assign a3_prod = 62'(a2_reg) * 62'(a_reg);
    assign pp_sum  = 32'(a_reg) + {a_reg, 1'b0} - 32'(a3_reg);
    assign s_val   = neg_reg ? (bpw_pkg::ONE_Q30 + 32'(a_reg))
                             : (bpw_pkg::ONE_Q30 - 32'(a_reg));
    assign w_prod  = 64'(w_reg) * 64'(s_val);

    // iterative unit control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg  <= 1'b0;
            div_busy_reg <= 1'b0;
        end
        else
        begin
            if (dcmd.op == bpw_pkg::OP_SQRT_GO)
            begin
                sq_busy_reg <= 1'b1;
            end
            else if (sq_busy_reg && sbit_reg == 64'd1)
            begin
                sq_busy_reg <= 1'b0;
            end
            if (dcmd.op == bpw_pkg::OP_DIV_U_GO || dcmd.op == bpw_pkg::OP_DIV_W_GO)
            begin
                div_busy_reg <= 1'b1;
            end
            else if (div_busy_reg && dcnt_reg == 6'd1)
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        // square root
        if (dcmd.op == bpw_pkg::OP_SQRT_GO)
        begin
            sv_reg   <= sum_reg;
            sr_reg   <= '0;
            sbit_reg <= bpw_pkg::SQRT_TOP;
        end
        else if (sq_busy_reg)
        begin
            if (sq_ge)
            begin
                sv_reg <= sv_reg - sq_t;
                sr_reg <= (sr_reg >> 1) + sbit_reg;
            end
            else
            begin
                sr_reg <= sr_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end

        // divider
        if (dcmd.op == bpw_pkg::OP_DIV_U_GO)
        begin
            dr_reg   <= (DW+1)'(num_reg);
            dd_reg   <= DW'(sr_reg[31:0]);
            dcnt_reg <= bpw_pkg::DIV_U_STEPS;
            dq_reg   <= '0;
        end
        else if (dcmd.op == bpw_pkg::OP_DIV_W_GO)
        begin
            dr_reg   <= (DW+1)'(wt_reg);
            dd_reg   <= total_reg;
            dcnt_reg <= bpw_pkg::DIV_W_STEPS;
            dq_reg   <= '0;
        end
        else if (div_busy_reg)
        begin
            dr_reg   <= {dv_rs[DW-1:0], 1'b0};
            dq_reg   <= {dq_reg[30:0], dv_ge};
            dcnt_reg <= dcnt_reg - 6'd1;
        end

        case (dcmd.op)
            bpw_pkg::OP_LOAD_PT:
            begin
                pt_x_reg  <= coord_x;
                pt_y_reg  <= coord_y;
                pt_z_reg  <= coord_z;
                total_reg <= '0;
                wt_reg    <= '0;
            end
            bpw_pkg::OP_DIFF_PT:
            begin
                dx_reg <= halfmag(pt_x_reg, rd_x);
                dy_reg <= halfmag(pt_y_reg, rd_y);
                dz_reg <= halfmag(pt_z_reg, rd_z);
            end
            bpw_pkg::OP_DIFF_CI:
            begin
                dx_reg <= halfmag(ci_x_reg, rd_x);
                dy_reg <= halfmag(ci_y_reg, rd_y);
                dz_reg <= halfmag(ci_z_reg, rd_z);
                lj_reg <= lam_rdata;
            end
            bpw_pkg::OP_SQUARE:
            begin
                sqx_reg <= 64'(dx_reg) * 64'(dx_reg);
                sqy_reg <= 64'(dy_reg) * 64'(dy_reg);
                sqz_reg <= 64'(dz_reg) * 64'(dz_reg);
            end
            bpw_pkg::OP_SUM:
            begin
                sum_reg <= sqx_reg + sqy_reg + sqz_reg;
            end
            bpw_pkg::OP_ROW_LATCH:
            begin
                ci_x_reg <= rd_x;
                ci_y_reg <= rd_y;
                ci_z_reg <= rd_z;
                li_reg   <= lam_rdata;
                w_reg    <= bpw_pkg::ONE_Q31;
            end
            bpw_pkg::OP_UPREP:
            begin
                neg_reg <= (li_reg < lj_reg);
                num_reg <= (li_reg < lj_reg) ? (lj_reg - li_reg) : (li_reg - lj_reg);
            end
            bpw_pkg::OP_A_SAT:
            begin
                a_reg <= bpw_pkg::ONE_Q30[30:0];
            end
            bpw_pkg::OP_TAKE_Q:
            begin
                a_reg <= dq_reg[30:0];
            end
            bpw_pkg::OP_A2:
            begin
                a2_reg <= a2_prod[60:30];
            end
            bpw_pkg::OP_A3:
            begin
                a3_reg <= a3_prod[60:30];
            end
            bpw_pkg::OP_PP:
            begin
                a_reg <= pp_sum[31:1];
            end
            bpw_pkg::OP_WMUL:
            begin
                w_reg <= w_prod[62:31];
            end
            bpw_pkg::OP_ROW_END:
            begin
                total_reg <= total_reg + bpw_pkg::TOT_W'(w_reg);
                if (dcmd.tgt)
                begin
                    wt_reg <= w_reg;
                end
            end
            bpw_pkg::OP_OUT:
            begin
                weight_reg <= (dcmd.st == bpw_pkg::ST_OK) ? dq_reg : 32'd0;
                status_reg <= dcmd.st;
            end
            default:
            begin
            end
        endcase
    end

    assign dstat.sqrt_busy  = sq_busy_reg;
    assign dstat.div_busy   = div_busy_reg;
    assign dstat.root_zero  = (sr_reg[31:0] == 32'd0);
    assign dstat.u_sat      = (num_reg >= sr_reg[31:0]);
    assign dstat.total_zero = (total_reg == '0);

    assign cell_weight = weight_reg;
    assign status      = status_reg;

endmodule

/* rtl/core/bpw_ctrl.sv */
module bpw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [3:0]        atom_index,
    output logic              out_valid,
    input  logic              out_ready,
    input  logic              cfg_we,
    input  logic [4:0]        cfg_wdata,
    output bpw_pkg::dp_cmd_t  dcmd,
    input  bpw_pkg::dp_stat_t dstat
);

    localparam int CW = bpw_pkg::CNT_W;
    localparam int AW = bpw_pkg::ADDR_W;

    typedef enum logic [4:0] {
        S_IDLE, L_RD, L_DIFF, L_SQ, L_SUM, L_SQGO, L_SQW, L_WR,
        R_RD, R_LAT, P_CHK, P_RD, P_DIFF, P_SQ, P_SUM, P_SQGO, P_SQW,
        P_ZCHK, P_USEL, P_DIVW, P_TAKEQ, P_A2, P_A3, P_PP, P_WMUL,
        R_END, W_CHK, W_DIVW, S_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic [4:0]       natoms_reg, natoms_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [CW-1:0]    i_reg, i_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [1:0]       pk_reg, pk_next;
    bpw_pkg::status_t st_reg, st_next;
    logic             ovalid_reg, ovalid_next;

    logic [CW-1:0]    n_clamp;
    logic             take;
    logic             out_free;

    assign n_clamp  = (32'(natoms_reg) > bpw_pkg::MAX_ATOMS)
                      ? CW'(bpw_pkg::MAX_ATOMS) : CW'(natoms_reg);
    assign in_ready = (state_reg == S_IDLE);
    assign take     = in_valid && in_ready;
    assign out_free = !ovalid_reg || out_ready;
    assign out_valid = ovalid_reg;

    // next state, counters and datapath command
    always_comb
    begin
        state_next  = state_reg;
        natoms_next = cfg_we ? cfg_wdata : natoms_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        idx_next    = idx_reg;
        pk_next     = pk_reg;
        st_next     = st_reg;
        ovalid_next = ovalid_reg && !out_ready;
        dcmd.op     = bpw_pkg::OP_NONE;
        dcmd.addr   = i_reg[AW-1:0];
        dcmd.tgt    = (i_reg == idx_reg);
        dcmd.st     = st_reg;

        case (state_reg)
            S_IDLE:
            begin
                dcmd.addr = AW'(atom_index);
                if (take && cmd == bpw_pkg::CMD_LOAD)
                begin
                    if (32'(atom_index) < bpw_pkg::MAX_ATOMS)
                    begin
                        dcmd.op = bpw_pkg::OP_STORE;
                    end
                end
                else if (take)
                begin
                    dcmd.op  = bpw_pkg::OP_LOAD_PT;
                    n_next   = n_clamp;
                    idx_next = CW'(atom_index);
                    i_next   = '0;
                    if (32'(atom_index) >= 32'(n_clamp))
                    begin
                        st_next    = bpw_pkg::ST_BADIDX;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = L_RD;
                    end
                end
            end
            // distances from the point to every atom
            L_RD:   state_next = L_DIFF;
            L_DIFF:
            begin
                dcmd.op    = bpw_pkg::OP_DIFF_PT;
                state_next = L_SQ;
            end
            L_SQ:
            begin
                dcmd.op    = bpw_pkg::OP_SQUARE;
                state_next = L_SUM;
            end
            L_SUM:
            begin
                dcmd.op    = bpw_pkg::OP_SUM;
                state_next = L_SQGO;
            end
            L_SQGO:
            begin
                dcmd.op    = bpw_pkg::OP_SQRT_GO;
                state_next = L_SQW;
            end
            L_SQW:
            begin
                if (!dstat.sqrt_busy)
                begin
                    state_next = L_WR;
                end
            end
            L_WR:
            begin
                dcmd.op = bpw_pkg::OP_LAM_WR;
                if (i_reg == n_reg - CW'(1))
                begin
                    i_next = '0;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                end
                state_next = (i_reg == n_reg - CW'(1)) ? R_RD : L_RD;
            end
            // one row of the cell function product per atom
            R_RD:   state_next = R_LAT;
            R_LAT:
            begin
                dcmd.op    = bpw_pkg::OP_ROW_LATCH;
                j_next     = '0;
                state_next = P_CHK;
            end
            P_CHK:
            begin
                if (j_reg == n_reg)
                begin
                    state_next = R_END;
                end
                else if (j_reg == i_reg)
                begin
                    j_next = j_reg + CW'(1);
                end
                else
                begin
                    state_next = P_RD;
                end
            end
            P_RD:
            begin
                dcmd.addr  = j_reg[AW-1:0];
                state_next = P_DIFF;
            end
            P_DIFF:
            begin
                dcmd.op    = bpw_pkg::OP_DIFF_CI;
                state_next = P_SQ;
            end
            P_SQ:
            begin
                dcmd.op    = bpw_pkg::OP_SQUARE;
                state_next = P_SUM;
            end
            P_SUM:
            begin
                dcmd.op    = bpw_pkg::OP_SUM;
                state_next = P_SQGO;
            end
            P_SQGO:
            begin
                dcmd.op    = bpw_pkg::OP_SQRT_GO;
                state_next = P_SQW;
            end
            P_SQW:
            begin
                if (!dstat.sqrt_busy)
                begin
                    state_next = P_ZCHK;
                end
            end
            P_ZCHK:
            begin
                dcmd.op = bpw_pkg::OP_UPREP;
                if (dstat.root_zero)
                begin
                    st_next    = bpw_pkg::ST_COINC;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = P_USEL;
                end
            end
            P_USEL:
            begin
                pk_next = '0;
                if (dstat.u_sat)
                begin
                    dcmd.op    = bpw_pkg::OP_A_SAT;
                    state_next = P_A2;
                end
                else
                begin
                    dcmd.op    = bpw_pkg::OP_DIV_U_GO;
                    state_next = P_DIVW;
                end
            end
            P_DIVW:
            begin
                if (!dstat.div_busy)
                begin
                    state_next = P_TAKEQ;
                end
            end
            P_TAKEQ:
            begin
                dcmd.op    = bpw_pkg::OP_TAKE_Q;
                state_next = P_A2;
            end
            // three passes of the smoothing polynomial
            P_A2:
            begin
                dcmd.op    = bpw_pkg::OP_A2;
                state_next = P_A3;
            end
            P_A3:
            begin
                dcmd.op    = bpw_pkg::OP_A3;
                state_next = P_PP;
            end
            P_PP:
            begin
                dcmd.op = bpw_pkg::OP_PP;
                if (pk_reg == 2'd2)
                begin
                    state_next = P_WMUL;
                end
                else
                begin
                    pk_next    = pk_reg + 2'd1;
                    state_next = P_A2;
                end
            end
            P_WMUL:
            begin
                dcmd.op    = bpw_pkg::OP_WMUL;
                j_next     = j_reg + CW'(1);
                state_next = P_CHK;
            end
            R_END:
            begin
                dcmd.op = bpw_pkg::OP_ROW_END;
                if (i_reg == n_reg - CW'(1))
                begin
                    state_next = W_CHK;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = R_RD;
                end
            end
            // normalize the target product
            W_CHK:
            begin
                if (dstat.total_zero)
                begin
                    st_next    = bpw_pkg::ST_ZERO;
                    state_next = S_FIN;
                end
                else
                begin
                    dcmd.op    = bpw_pkg::OP_DIV_W_GO;
                    state_next = W_DIVW;
                end
            end
            W_DIVW:
            begin
                if (!dstat.div_busy)
                begin
                    st_next    = bpw_pkg::ST_OK;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    dcmd.op     = bpw_pkg::OP_OUT;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            natoms_reg <= 5'd1;
            n_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            idx_reg    <= '0;
            pk_reg     <= '0;
            st_reg     <= bpw_pkg::ST_OK;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            natoms_reg <= natoms_next;
            n_reg      <= n_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            idx_reg    <= idx_next;
            pk_reg     <= pk_next;
            st_reg     <= st_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

/* sim/tb_becke_partition_weight.sv */
`timescale 1ns / 1ps

module tb_becke_partition_weight;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               cmd;
    logic [3:0]         atom_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               out_valid;
    logic               out_ready;
    logic [31:0]        cell_weight;
    logic [1:0]         status;
    logic               cfg_we;
    logic [4:0]         cfg_wdata;

    localparam longint unsigned Q30 = 64'd1 << 30;
    localparam longint unsigned Q31 = 64'd1 << 31;

    typedef struct {
        logic [31:0]      weight;
        bpw_pkg::status_t st;
    } weight_res_t;

    typedef struct {
        int               ncfg;     // -1 keeps the atom count
        logic             cmd;
        logic [3:0]       idx;
        logic [31:0]      x, y, z;
        bit               typed;
        logic [31:0]      weight;
        bpw_pkg::status_t st;
    } plan_row_t;

    // model state: atom centres and count
    logic signed [31:0] ctr_x [bpw_pkg::MAX_ATOMS];
    logic signed [31:0] ctr_y [bpw_pkg::MAX_ATOMS];
    logic signed [31:0] ctr_z [bpw_pkg::MAX_ATOMS];
    logic [4:0]         atom_cnt;

    weight_res_t pending_weights [$];
    plan_row_t   plan [$];
    int          errors;
    int          idle_pct;
    int          stall_pct;

    becke_partition_weight dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .atom_index (atom_index),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_weight(cell_weight),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // floor integer square root
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned half_diff(longint a, longint b);
        longint d;
        longint unsigned m;
        d = a - b;
        m = (d < 0) ? longint'(-d) : d;
        return m >> 1;
    endfunction

    // distance in units of 2^-15 Bohr
    function automatic longint unsigned span(longint ax, longint ay, longint az,
                                             longint bx, longint by, longint bz);
        longint unsigned dx, dy, dz;
        dx = half_diff(ax, bx);
        dy = half_diff(ay, by);
        dz = half_diff(az, bz);
        return int_sqrt(dx * dx + dy * dy + dz * dz);
    endfunction

    function automatic longint unsigned cubic_step(longint unsigned a);
        longint unsigned a2, a3;
        a2 = (a * a) >> 30;
        a3 = (a2 * a) >> 30;
        return (3 * a - a3) >> 1;
    endfunction

    // switching function s(u) in Q31
    function automatic longint unsigned cell_switch(longint unsigned l1,
                                                    longint unsigned l2,
                                                    longint unsigned rij);
        bit neg;
        longint unsigned num, a;
        neg = l1 < l2;
        num = neg ? l2 - l1 : l1 - l2;
        a = (num << 30) / rij;
        if (a > Q30)
            a = Q30;
        a = cubic_step(cubic_step(cubic_step(a)));
        return neg ? Q30 + a : Q30 - a;
    endfunction

    // partition weight of target atom at grid point
    function automatic weight_res_t becke_weight(logic [3:0] tgt, logic signed [31:0] px,
                                                 logic signed [31:0] py,
                                                 logic signed [31:0] pz);
        weight_res_t     res;
        int              n;
        longint unsigned lam [bpw_pkg::MAX_ATOMS];
        longint unsigned total, wt, w, rij;
        res.weight = '0;
        n = (atom_cnt > bpw_pkg::MAX_ATOMS) ? bpw_pkg::MAX_ATOMS : atom_cnt;
        total = 0;
        wt = 0;
        if (tgt >= n)
        begin
            res.st = bpw_pkg::ST_BADIDX;
            return res;
        end
        for (int i = 0; i < n; i++)
            lam[i] = span(px, py, pz, ctr_x[i], ctr_y[i], ctr_z[i]);
        for (int i = 0; i < n; i++)
        begin
            w = Q31;
            for (int j = 0; j < n; j++)
            begin
                if (i == j)
                    continue;
                rij = span(ctr_x[i], ctr_y[i], ctr_z[i], ctr_x[j], ctr_y[j], ctr_z[j]);
                if (rij == 0)
                begin
                    res.st = bpw_pkg::ST_COINC;
                    return res;
                end
                w = (w * cell_switch(lam[i], lam[j], rij)) >> 31;
            end
            if (i == tgt)
                wt = w;
            total += w;
        end
        if (total == 0)
        begin
            res.st = bpw_pkg::ST_ZERO;
            return res;
        end
        res.weight = 32'((wt << 31) / total);
        res.st = bpw_pkg::ST_OK;
        return res;
    endfunction

    // random coordinate: extremes, full range, or a cluster near the origin
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return $urandom;
            default: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
        endcase
    endfunction

    // drive one transaction and record what it should produce
    task automatic send_item(logic c, logic [3:0] idx, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, bit typed, logic [31:0] ew,
                             bpw_pkg::status_t est);
        weight_res_t r;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        atom_index <= idx;
        coord_x    <= x;
        coord_y    <= y;
        coord_z    <= z;
        do
            @(posedge clk);
        while (!in_ready);
        if (c == bpw_pkg::CMD_LOAD)
        begin
            ctr_x[idx] = x;
            ctr_y[idx] = y;
            ctr_z[idx] = z;
        end
        else
        begin
            r = becke_weight(idx, x, y, z);
            if (typed)
            begin
                r.weight = ew;
                r.st = est;
            end
            pending_weights = {pending_weights, r};
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_weights.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_atom_count(int v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v[4:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        atom_cnt  = v[4:0];
    endtask

    task automatic add_row(int ncfg, logic c, logic [3:0] idx, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z, bit typed = 0,
                           logic [31:0] ew = '0,
                           bpw_pkg::status_t est = bpw_pkg::ST_OK);
        plan_row_t p;
        p.ncfg = ncfg; p.cmd = c; p.idx = idx;
        p.x = x; p.y = y; p.z = z;
        p.typed = typed; p.weight = ew; p.st = est;
        plan = {plan, p};
    endtask

    // receiver stalls
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // result checker
    always @(posedge clk)
    begin
        weight_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_weights.size() == 0)
            begin
                $display("%0t: unexpected result weight=%h status=%0d",
                         $time, cell_weight, status);
                errors++;
            end
            else
            begin
                e = pending_weights.pop_front();
                if (cell_weight !== e.weight)
                begin
                    $display("%0t: cell_weight expected %h actual %h",
                             $time, e.weight, cell_weight);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int ncnt [8];
        int nitems;
        logic c;
        logic [3:0] idx;
        int n;
        ncnt       = '{2, 3, 1, 4, 0, 2, 5, 16};
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = bpw_pkg::CMD_LOAD;
        atom_index = '0;
        coord_x    = '0;
        coord_y    = '0;
        coord_z    = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        errors     = 0;
        idle_pct   = 0;
        stall_pct  = 0;
        atom_cnt   = 5'd1;
        for (int i = 0; i < bpw_pkg::MAX_ATOMS; i++)
        begin
            ctr_x[i] = '0; ctr_y[i] = '0; ctr_z[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: bad index after reset, lone atom, extremes, coincidence
        add_row(-1, bpw_pkg::CMD_EVAL, 4'd1, 0, 0, 0, 1, 32'd0, bpw_pkg::ST_BADIDX);
        add_row(-1, bpw_pkg::CMD_LOAD, 4'd0, 0, 0, 0);
        add_row(-1, bpw_pkg::CMD_EVAL, 4'd0, 32'h7fff_ffff, 32'h8000_0000, 0, 1,
                32'h8000_0000, bpw_pkg::ST_OK);
        add_row(-1, bpw_pkg::CMD_LOAD, 4'd1, 32'h0002_0000, 32'h0001_0000, 32'hffff_0000);
        add_row(2,  bpw_pkg::CMD_EVAL, 4'd0, 32'h0000_8000, 0, 0);
        add_row(-1, bpw_pkg::CMD_EVAL, 4'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_row(-1, bpw_pkg::CMD_EVAL, 4'd15, 0, 0, 0, 1, 32'd0, bpw_pkg::ST_BADIDX);
        add_row(-1, bpw_pkg::CMD_LOAD, 4'd2, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001);
        add_row(3,  bpw_pkg::CMD_EVAL, 4'd2, 32'h0001_0000, 0, 0, 1, 32'd0,
                bpw_pkg::ST_COINC);
        add_row(0,  bpw_pkg::CMD_EVAL, 4'd0, 0, 0, 0, 1, 32'd0, bpw_pkg::ST_BADIDX);
        for (int i = 3; i < bpw_pkg::MAX_ATOMS; i++)
            add_row(-1, bpw_pkg::CMD_LOAD, i[3:0], i * 32'h0003_1000,
                    32'h0001_0000 - i * 32'h2_0000,
                    (i % 2) ? 32'h7fff_ffff : 32'h8000_0000);
        add_row(-1, bpw_pkg::CMD_LOAD, 4'd2, 32'h0000_0000, 32'h0004_0000, 32'hfffc_0000);
        add_row(31, bpw_pkg::CMD_EVAL, 4'd15, 32'h0001_2345, 32'hfff0_0000, 32'h0000_0100);
        add_row(3,  bpw_pkg::CMD_EVAL, 4'd2, 32'h0000_0000, 32'h0003_0000, 32'hfffd_0000);

        foreach (plan[k])
        begin
            if (plan[k].ncfg >= 0)
                set_atom_count(plan[k].ncfg);
            send_item(plan[k].cmd, plan[k].idx, plan[k].x, plan[k].y, plan[k].z,
                      plan[k].typed, plan[k].weight, plan[k].st);
        end

        // random phases; every slot is already loaded
        for (int ph = 0; ph < 8; ph++)
        begin
            set_atom_count(ncnt[ph]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 66; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 66; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            nitems = (ncnt[ph] == 16) ? 20 : 162;
            n = (ncnt[ph] == 0) ? 1 : ncnt[ph];
            for (int k = 0; k < nitems; k++)
            begin
                c = 1'($urandom_range(1));
                if (c == bpw_pkg::CMD_LOAD || $urandom_range(9) < 2)
                    idx = 4'($urandom_range(15));
                else
                    idx = 4'($urandom_range(n - 1));
                send_item(c, idx, rand_coord(), rand_coord(), rand_coord(),
                          0, '0, bpw_pkg::ST_OK);
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (errors == 0 && pending_weights.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
